// ----- hdl/lmsp_pkg.sv -----
// Package: request kinds, result types and cell layout constants for the shadow plotter.
package lmsp_pkg;

  localparam int CELL_W   = 8;
  localparam int NIB_W    = 4;
  localparam int KIND_W   = 3;
  localparam int COORD_W  = 8;
  localparam int MASK_W   = 2;
  localparam int CADDR_W  = 6;
  localparam int ROW_W    = 3;

  localparam logic [ROW_W-1:0] ROW_LAST = 3'd7;
  localparam logic [NIB_W-1:0] NIB_TOP  = 4'b1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLOT      = 3'd0,
    KIND_PLOT_RAM  = 3'd1,
    KIND_SNAPSHOT  = 3'd2,
    KIND_CLEAR     = 3'd3,
    KIND_READ      = 3'd4
  } kind_t;

  typedef enum logic {
    RES_CELL_WRITE = 1'b0,
    RES_SNAP_READ  = 1'b1
  } result_type_t;

endpackage

// ----- hdl/lmsp_if.sv -----
// Interfaces: request and result channels with valid/ready transfer.
interface lmsp_req_if;
  logic                         valid;
  logic                         ready;
  logic [lmsp_pkg::KIND_W-1:0]  kind;
  logic [lmsp_pkg::COORD_W-1:0] column;
  logic [lmsp_pkg::COORD_W-1:0] row;
  logic                         pixel_on;
  logic                         wrap_mode;

  modport source (output valid, kind, column, row, pixel_on, wrap_mode, input ready);
  modport sink   (input valid, kind, column, row, pixel_on, wrap_mode, output ready);
endinterface

interface lmsp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         result_type;
  logic [lmsp_pkg::MASK_W-1:0]  panel_mask;
  logic [lmsp_pkg::CADDR_W-1:0] cell_address;
  logic [lmsp_pkg::NIB_W-1:0]   cell_nibble;
  logic                         snapshot_pixel;

  modport source (output valid, result_type, panel_mask, cell_address, cell_nibble,
                  snapshot_pixel, input ready);
  modport sink   (input valid, result_type, panel_mask, cell_address, cell_nibble,
                  snapshot_pixel, output ready);
endinterface

// ----- hdl/lmsp_sub.sv -----
// Shared subtract-and-compare unit used by the plot sequencer.
module lmsp_sub #(
  parameter int W = 10
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] wide;

  // no borrow out of the extended subtract means a >= b
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[W-1:0];
  assign ge   = ~wide[W];

endmodule

// ----- hdl/lmsp_store.sv -----
// Cell store: one write port, one registered read port.
module lmsp_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lmsp_pkg::CELL_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [lmsp_pkg::CELL_W-1:0] rdata
);

  logic [lmsp_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/led_matrix_shadow_plotter.sv -----
// Top level: frame buffer sequencer for panels of 4-bit LED driver cells.
//
// Each cell byte holds a live nibble (low) and a snapshot nibble (high); pixel (x, y) sits in
// cell 2x + y/4. After reset the block zeroes all STORE_CELLS cells of the store and takes no
// request until that pass is done; panel_count writes are taken at any time. One request is
// worked at a time through a small sequencer around a single subtract/compare unit. A plot or
// read first fixes the column (clamped, or wrapped by repeated subtraction), then splits it
// into panel and in-panel column by repeated subtraction, then reads the store cell and
// modifies it. Snapshot and clear walk the active cells, reading and then writing each one.
// A finished result sits in an output register; the next request is accepted while it waits,
// and only a further result stalls in its modify step until the register frees. Kinds five
// to seven are dropped.
module led_matrix_shadow_plotter #(
  parameter int PANEL_COLUMNS = 32,
  parameter int PANEL_LIMIT   = 2,
  parameter int STORE_CELLS   = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  lmsp_req_if.sink   req,
  lmsp_rsp_if.source rsp
);

  localparam int AW   = $clog2(STORE_CELLS);
  localparam int FIT  = STORE_CELLS / (2 * PANEL_COLUMNS);
  localparam int CAP  = (FIT < PANEL_LIMIT) ? ((FIT < 1) ? 1 : FIT) : PANEL_LIMIT;
  localparam int SPAN = 2 * PANEL_LIMIT * PANEL_COLUMNS;
  localparam int UWA  = $clog2(SPAN + 1);
  localparam int UWB  = $clog2(STORE_CELLS + 1);
  // 9 bits cover a cell address built from any 8-bit column
  localparam int UWC  = (UWA > UWB) ? UWA : UWB;
  localparam int UW   = (UWC > 9) ? UWC : 9;
  localparam int PW   = (PANEL_LIMIT > 1) ? $clog2(PANEL_LIMIT) : 1;
  localparam int CW   = lmsp_pkg::CELL_W;
  localparam int NW   = lmsp_pkg::NIB_W;

  localparam logic [2:0]    CAP_P    = 3'(CAP);
  localparam logic [UW-1:0] PCOLS    = UW'(PANEL_COLUMNS);
  localparam logic [UW-1:0] CELLS_UW = UW'(STORE_CELLS);
  localparam logic [AW-1:0] LAST_IDX = AW'(STORE_CELLS - 1);

  typedef enum logic [7:0] {
    ST_CLR   = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_FIXX  = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_RD    = 8'b0001_0000,
    ST_MOD   = 8'b0010_0000,
    ST_SW_RD = 8'b0100_0000,
    ST_SW_WR = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration and request registers
  logic [1:0]                      pcount;
  logic [lmsp_pkg::KIND_W-1:0]     kind_r;
  logic [UW-1:0]                   x_r;
  logic [lmsp_pkg::ROW_W-1:0]      y_r;
  logic                            on_r;
  logic                            wrap_r;
  logic [UW-1:0]                   addr_r;
  logic [PW-1:0]                   panel_r;
  logic [UW-1:0]                   idx;

  // result register
  logic                            out_valid;
  logic                            out_type;
  logic [lmsp_pkg::MASK_W-1:0]     out_mask;
  logic [lmsp_pkg::CADDR_W-1:0]    out_caddr;
  logic [NW-1:0]                   out_nib;
  logic                            out_snap;

  // active geometry
  logic [2:0]                      p_act;
  logic [UW-1:0]                   col_count;
  logic [UW-1:0]                   cells;

  // shared unit
  logic [UW-1:0]                   su_a;
  logic [UW-1:0]                   su_b;
  logic [UW-1:0]                   su_diff;
  logic                            su_ge;

  // store port
  logic                            st_we;
  logic [AW-1:0]                   st_waddr;
  logic [CW-1:0]                   st_wdata;
  logic [AW-1:0]                   st_raddr;
  logic [CW-1:0]                   st_rdata;

  // modify stage
  logic                            in_range;
  logic [CW-1:0]                   cell_b;
  logic [NW-1:0]                   bit_sel;
  logic [CW-1:0]                   cell_new;
  logic                            snap_bit;
  logic                            need_out;
  logic                            can_load;
  logic [UW-1:0]                   caddr_full;
  logic [lmsp_pkg::ROW_W-1:0]      y_fix;

  // panel count: 0 acts as 1, then limited to PANEL_LIMIT and to what the store holds
  always_comb begin
    p_act = (pcount == 2'd0) ? 3'd1 : {1'b0, pcount};
    if (p_act > CAP_P) begin
      p_act = CAP_P;
    end
  end

  assign col_count = UW'(p_act * PANEL_COLUMNS);
  assign cells     = ({col_count, 1'b0} > {1'b0, CELLS_UW}) ? CELLS_UW : UW'({col_count, 1'b0});

  // one unit serves column fix, panel split and sweep bound
  always_comb begin
    su_a = x_r;
    su_b = col_count;
    case (state)
      ST_DIV: begin
        su_b = PCOLS;
      end
      ST_SW_RD: begin
        su_a = idx;
        su_b = cells;
      end
      default: begin
        su_a = x_r;
        su_b = col_count;
      end
    endcase
  end

  lmsp_sub #(.W(UW)) u_sub (
    .a    (su_a),
    .b    (su_b),
    .diff (su_diff),
    .ge   (su_ge)
  );

  // pixel bit and read-modify-write of the addressed cell
  assign in_range   = (addr_r < CELLS_UW);
  assign cell_b     = in_range ? st_rdata : '0;
  assign bit_sel    = lmsp_pkg::NIB_TOP >> y_r[1:0];
  assign cell_new   = on_r ? (cell_b | {{(CW-NW){1'b0}}, bit_sel})
                           : (cell_b & ~{{(CW-NW){1'b0}}, bit_sel});
  assign snap_bit   = |(cell_b[CW-1:NW] & bit_sel);
  assign need_out   = (kind_r != lmsp_pkg::KIND_PLOT_RAM);
  assign can_load   = ~out_valid | rsp.ready;
  assign caddr_full = {x_r[UW-2:0], 1'b0} + UW'(y_r[2]);

  // row rule: wrap keeps the low three bits, clamp pins to the last row
  assign y_fix = ((req.row > 8'(lmsp_pkg::ROW_LAST)) && !req.wrap_mode)
               ? lmsp_pkg::ROW_LAST : req.row[lmsp_pkg::ROW_W-1:0];

  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx[AW-1:0];
    st_wdata = '0;
    st_raddr = (state == ST_SW_RD) ? idx[AW-1:0] : addr_r[AW-1:0];
    case (state)
      ST_CLR: begin
        st_we = 1'b1;
      end
      ST_SW_WR: begin
        st_we    = 1'b1;
        st_wdata = (kind_r == lmsp_pkg::KIND_SNAPSHOT)
                 ? {st_rdata[NW-1:0], st_rdata[NW-1:0]}
                 : {st_rdata[CW-1:NW], {NW{1'b0}}};
      end
      ST_MOD: begin
        // write once, on the cycle the request retires
        st_we    = in_range && (kind_r != lmsp_pkg::KIND_READ) && (!need_out || can_load);
        st_waddr = addr_r[AW-1:0];
        st_wdata = cell_new;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  lmsp_store #(.DEPTH(STORE_CELLS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= 2'd2;
    end else if (cfg_we) begin
      pcount <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      idx   <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          idx <= idx + 1'b1;
          if (idx[AW-1:0] == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            idx <= '0;
            case (req.kind) inside
              lmsp_pkg::KIND_PLOT, lmsp_pkg::KIND_PLOT_RAM, lmsp_pkg::KIND_READ: begin
                state <= ST_FIXX;
              end
              lmsp_pkg::KIND_SNAPSHOT, lmsp_pkg::KIND_CLEAR: begin
                state <= ST_SW_RD;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_FIXX: begin
          if (!su_ge) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!su_ge) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_MOD;
        end
        ST_MOD: begin
          if (!need_out || can_load) begin
            state <= ST_IDLE;
          end
        end
        ST_SW_RD: begin
          state <= su_ge ? ST_IDLE : ST_SW_WR;
        end
        ST_SW_WR: begin
          idx   <= idx + 1'b1;
          state <= ST_SW_RD;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        kind_r <= req.kind;
        x_r    <= UW'(req.column);
        y_r    <= y_fix;
        on_r   <= req.pixel_on;
        wrap_r <= req.wrap_mode;
      end
      ST_FIXX: begin
        if (su_ge) begin
          x_r <= wrap_r ? su_diff : (col_count - 1'b1);
        end else begin
          addr_r  <= {x_r[UW-2:0], 1'b0} + UW'(y_r[2]);
          panel_r <= '0;
        end
      end
      ST_DIV: begin
        if (su_ge) begin
          x_r     <= su_diff;
          panel_r <= panel_r + 1'b1;
        end
      end
      default: begin
        x_r <= x_r;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_MOD) && need_out && can_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_MOD) && need_out && can_load) begin
      if (kind_r == lmsp_pkg::KIND_READ) begin
        out_type  <= lmsp_pkg::RES_SNAP_READ;
        out_mask  <= '0;
        out_caddr <= '0;
        out_nib   <= '0;
        out_snap  <= snap_bit;
      end else begin
        out_type  <= lmsp_pkg::RES_CELL_WRITE;
        out_mask  <= (panel_r == PW'(0)) ? 2'b01 :
                     (panel_r == PW'(1)) ? 2'b10 : 2'b00;
        out_caddr <= caddr_full[lmsp_pkg::CADDR_W-1:0];
        out_nib   <= cell_new[NW-1:0];
        out_snap  <= 1'b0;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.result_type    = out_type;
  assign rsp.panel_mask     = out_mask;
  assign rsp.cell_address   = out_caddr;
  assign rsp.cell_nibble    = out_nib;
  assign rsp.snapshot_pixel = out_snap;

endmodule

// ----- tb/led_matrix_shadow_plotter_tb.sv -----
// Testbench for the LED matrix shadow plotter: random and directed requests with a scoreboard.
module led_matrix_shadow_plotter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Field widths taken from the package.
  localparam int KIND_W  = lmsp_pkg::KIND_W;
  localparam int COORD_W = lmsp_pkg::COORD_W;
  localparam int MASK_W  = lmsp_pkg::MASK_W;
  localparam int CADDR_W = lmsp_pkg::CADDR_W;
  localparam int NIB_W   = lmsp_pkg::NIB_W;
  localparam int CELL_W  = lmsp_pkg::CELL_W;

  // Block geometry; the DUT is built with the same values.
  localparam int PANEL_COLUMNS = 32;
  localparam int PANEL_LIMIT   = 2;
  localparam int STORE_CELLS   = 128;
  localparam int ROW_COUNT     = 8;

  // Kinds five to seven carry no meaning and must be dropped by the block.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  // Snapshot or clear walks every active cell with a read and then a write,
  // so a quiet spell of this length covers any request that gives no result.
  localparam int SETTLE_CYCLES = 2 * STORE_CELLS + 40;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 235;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               pixel_on;
    logic               wrap_mode;
  } plot_request_t;

  typedef struct packed {
    logic                result_type;
    logic [MASK_W-1:0]   panel_mask;
    logic [CADDR_W-1:0]  cell_address;
    logic [NIB_W-1:0]    cell_nibble;
    logic                snapshot_pixel;
  } plot_result_t;

  // Shadow of the cell store and panel count; predicts each result and
  // matches it against the transfers leaving the block.
  class plot_scoreboard;
    logic [CELL_W-1:0] cells [STORE_CELLS];
    logic [1:0]        panel_reg;
    plot_result_t      due [$];
    int unsigned       errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      panel_reg = 2'd2;
      errors    = 0;
    endfunction

    function void set_panels(logic [1:0] value);
      panel_reg = value;
    endfunction

    function int unsigned live_panels();
      int unsigned p;
      int unsigned fit;
      p   = panel_reg;
      fit = STORE_CELLS / (2 * PANEL_COLUMNS);
      if (p < 1) p = 1;
      if (p > PANEL_LIMIT) p = PANEL_LIMIT;
      if (p > fit) p = fit;
      if (p < 1) p = 1;
      return p;
    endfunction

    function int unsigned live_columns();
      return live_panels() * PANEL_COLUMNS;
    endfunction

    function int unsigned live_cells();
      int unsigned n;
      n = live_panels() * 2 * PANEL_COLUMNS;
      if (n > STORE_CELLS) n = STORE_CELLS;
      return n;
    endfunction

    function int unsigned fix_coord(int unsigned v, int unsigned count, logic wrap);
      if (v >= count) v = wrap ? (v % count) : (count - 1);
      return v;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void note_request(plot_request_t rq);
      int unsigned  x;
      int unsigned  y;
      int unsigned  addr;
      int unsigned  panel;
      logic [7:0]   b;
      plot_result_t r;
      case (rq.kind)
        lmsp_pkg::KIND_SNAPSHOT: begin
          for (int i = 0; i < live_cells(); i++) cells[i] = {cells[i][3:0], cells[i][3:0]};
        end
        lmsp_pkg::KIND_CLEAR: begin
          for (int i = 0; i < live_cells(); i++) cells[i][3:0] = 4'h0;
        end
        lmsp_pkg::KIND_PLOT, lmsp_pkg::KIND_PLOT_RAM, lmsp_pkg::KIND_READ: begin
          x    = fix_coord(rq.column, live_columns(), rq.wrap_mode);
          y    = fix_coord(rq.row, ROW_COUNT, rq.wrap_mode);
          addr = (x << 1) + (y >> 2);
          b    = (addr < STORE_CELLS) ? cells[addr] : 8'h00;
          r    = '0;
          if (rq.kind == lmsp_pkg::KIND_READ) begin
            r.result_type    = lmsp_pkg::RES_SNAP_READ;
            r.snapshot_pixel = b[7 - (y & 3)];
            due.push_back(r);
          end else begin
            b[3 - (y & 3)] = rq.pixel_on;
            if (addr < STORE_CELLS) cells[addr] = b;
            if (rq.kind == lmsp_pkg::KIND_PLOT) begin
              panel          = x / PANEL_COLUMNS;
              r.result_type  = lmsp_pkg::RES_CELL_WRITE;
              r.panel_mask   = (panel < 2) ? MASK_W'((1 << panel) & 3) : '0;
              r.cell_address = CADDR_W'(((x % PANEL_COLUMNS) << 1) + (y >> 2));
              r.cell_nibble  = b[3:0];
              due.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(plot_result_t got);
      plot_result_t exp;
      if (due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result type %0d mask %0d addr %0d nibble %0h pixel %0d",
                   $realtime, got.result_type, got.panel_mask, got.cell_address,
                   got.cell_nibble, got.snapshot_pixel);
        return;
      end
      exp = due.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display({"%0t: result mismatch, expected type %0d mask %0d addr %0d nibble %0h ",
                    "pixel %0d, got type %0d mask %0d addr %0d nibble %0h pixel %0d"},
                   $realtime, exp.result_type, exp.panel_mask, exp.cell_address,
                   exp.cell_nibble, exp.snapshot_pixel, got.result_type, got.panel_mask,
                   got.cell_address, got.cell_nibble, got.snapshot_pixel);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_data;

  lmsp_req_if req_ch ();
  lmsp_rsp_if rsp_ch ();

  plot_scoreboard sb;
  int unsigned    cycle_count;

  led_matrix_shadow_plotter #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .PANEL_LIMIT   (PANEL_LIMIT),
    .STORE_CELLS   (STORE_CELLS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or lost result ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: every transfer out of the block is checked against the oldest prediction.
  // Sampled at the rising edge, while inputs only move on the falling edge.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_result('{result_type:    rsp_ch.result_type,
                        panel_mask:     rsp_ch.panel_mask,
                        cell_address:   rsp_ch.cell_address,
                        cell_nibble:    rsp_ch.cell_nibble,
                        snapshot_pixel: rsp_ch.snapshot_pixel});
  end

  // Receiver back-pressure: the pattern switches at random between always ready,
  // coin-toss, a rotating bit pattern and heavy stalling, so stalls land on every phase of a
  // result, including the case where a finished result waits and the next one queues behind.
  initial begin
    int unsigned mode;
    int unsigned span;
    logic [7:0]  pat;
    mode          = 0;
    span          = 0;
    pat           = 8'b1011_0110;
    rsp_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 96);
      end
      span--;
      pat = {pat[6:0], pat[7]};
      case (mode)
        0:       rsp_ch.ready = 1'b1;
        1:       rsp_ch.ready = 1'($urandom_range(0, 1));
        2:       rsp_ch.ready = pat[0];
        default: rsp_ch.ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic plot_request_t item_of(logic [KIND_W-1:0] kind, int unsigned column,
                                            int unsigned row, logic on, logic wrap);
    plot_request_t rq;
    rq.kind      = kind;
    rq.column    = COORD_W'(column);
    rq.row       = COORD_W'(row);
    rq.pixel_on  = on;
    rq.wrap_mode = wrap;
    return rq;
  endfunction

  // Present one request from the next falling edge and hold it until the transfer.
  // valid stays high afterwards; the next request or an idle cycle replaces it.
  task automatic send_item(plot_request_t rq);
    @(negedge clk);
    req_ch.valid     = 1'b1;
    req_ch.kind      = rq.kind;
    req_ch.column    = rq.column;
    req_ch.row       = rq.row;
    req_ch.pixel_on  = rq.pixel_on;
    req_ch.wrap_mode = rq.wrap_mode;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(rq);
  endtask

  task automatic idle_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
  endtask

  // Wait until every predicted result has been taken, then let any walk in progress finish.
  task automatic drain();
    idle_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_panels(logic [1:0] value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    sb.set_panels(value);
  endtask

  function automatic logic [KIND_W-1:0] KIND_LAST_SPARE();
    return KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
  endfunction

  // Mostly plots and reads over the live area so that snapshot and clear have content to
  // move; a fifth of coordinates come from the full 8-bit range to exercise clamp and wrap.
  function automatic plot_request_t random_item();
    plot_request_t rq;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      rq.kind = lmsp_pkg::KIND_PLOT;
    else if (pick < 55) rq.kind = lmsp_pkg::KIND_PLOT_RAM;
    else if (pick < 62) rq.kind = lmsp_pkg::KIND_SNAPSHOT;
    else if (pick < 66) rq.kind = lmsp_pkg::KIND_CLEAR;
    else if (pick < 95) rq.kind = lmsp_pkg::KIND_READ;
    else                rq.kind = KIND_LAST_SPARE();
    if ($urandom_range(0, 4) == 0) begin
      rq.column = COORD_W'($urandom_range(0, 255));
      rq.row    = COORD_W'($urandom_range(0, 255));
    end else begin
      rq.column = COORD_W'($urandom_range(0, sb.live_columns() - 1));
      rq.row    = COORD_W'($urandom_range(0, ROW_COUNT - 1));
    end
    rq.pixel_on  = ($urandom_range(0, 3) != 0);
    rq.wrap_mode = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  // One random phase: bursts of back-to-back transfers with random gaps, the first stretch
  // without gaps at all. Dropped kinds do not count towards the phase length.
  task automatic run_random(int unsigned target);
    plot_request_t rq;
    int unsigned   counted;
    int unsigned   burst_left;
    counted    = 0;
    burst_left = 0;
    while (counted < target) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (counted > 40 && $urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 10));
      end
      burst_left--;
      rq = random_item();
      send_item(rq);
      if (rq.kind <= lmsp_pkg::KIND_READ) counted++;
    end
  endtask

  task automatic run_directed();
    // corners of the 64-column area, clamped and wrapped, set and cleared
    send_item(item_of(lmsp_pkg::KIND_PLOT,       0,   0, 1'b1, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_PLOT,      63,   7, 1'b1, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_PLOT,     255, 255, 1'b1, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_PLOT,     255, 255, 1'b0, 1'b1));
    send_item(item_of(lmsp_pkg::KIND_PLOT,      64,   8, 1'b1, 1'b1));
    send_item(item_of(lmsp_pkg::KIND_PLOT,      31,   3, 1'b1, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_PLOT,      32,   4, 1'b1, 1'b0));
    // store-only plot, then the snapshot must pick it up
    send_item(item_of(lmsp_pkg::KIND_PLOT_RAM,  32,   3, 1'b1, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_READ,      32,   3, 1'b0, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_SNAPSHOT,   0,   0, 1'b0, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_READ,      32,   3, 1'b0, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_READ,     128, 200, 1'b0, 1'b1));
    // clear wipes the live half only; the snapshot survives
    send_item(item_of(lmsp_pkg::KIND_CLEAR,    255, 255, 1'b1, 1'b1));
    send_item(item_of(lmsp_pkg::KIND_PLOT,      32,   5, 1'b1, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_READ,      32,   4, 1'b0, 1'b0));
    // dropped kinds, all three of them
    send_item(item_of(KIND_SPARE_LO,  10,   2, 1'b1, 1'b0));
    send_item(item_of(KIND_W'(KIND_SPARE_LO + 1), 20, 6, 1'b0, 1'b1));
    send_item(item_of(KIND_SPARE_HI, 255, 255, 1'b1, 1'b1));
    send_item(item_of(lmsp_pkg::KIND_PLOT,      31,   5, 1'b0, 1'b1));
    send_item(item_of(lmsp_pkg::KIND_READ,     255,   0, 1'b0, 1'b1));
    send_item(item_of(lmsp_pkg::KIND_READ,     200,   9, 1'b0, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_SNAPSHOT,  99,  99, 1'b1, 1'b0));
    send_item(item_of(lmsp_pkg::KIND_READ,     255, 255, 1'b0, 1'b0));
  endtask

  initial begin
    logic [1:0] panel_settings [4];
    panel_settings = '{2'd1, 2'd3, 2'd0, 2'd2};
    sb               = new();
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.kind      = lmsp_pkg::KIND_PLOT;
    req_ch.column    = '0;
    req_ch.row       = '0;
    req_ch.pixel_on  = 1'b0;
    req_ch.wrap_mode = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed checks run at the reset panel count; the block's clearing pass after reset
    // simply holds off the first transfer.
    run_directed();

    // Each random phase starts from an idle block with a new panel count: the valid
    // extremes one and two, plus zero and three, which act as one and two.
    foreach (panel_settings[i]) begin
      drain();
      write_panels(panel_settings[i]);
      run_random(PHASE_ITEMS);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
